>>> rtl/core/lagr_pkg.sv
// ----------------------------------------------------------------------------
// lagr_pkg: shared types and constants for the Lagrange interpolator
// Mode and status codes, Q32.32 limits, controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package lagr_pkg;

  localparam int unsigned MaxKnotsDef = 8;

  // largest Q32.32 magnitude, 2^63 - 1
  localparam logic [62:0] QLIM = '1;
  // 1.0 in Q32.32 magnitude form
  localparam logic [62:0] QONE = 63'h1_0000_0000;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_EVAL   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_SAT  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic {
    MUL_RATIO = 1'b0,
    MUL_TERM  = 1'b1
  } mul_sel_e;

  typedef struct packed {
    logic     eval_init;
    logic     ld_k;
    logic     div_start;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     ld_basis;
    logic     acc_add;
    logic     ld_out;
    logic     out_eval;
    status_e  out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic dup;
    logic div_busy;
    logic mul_busy;
  } dp_stat_t;

endpackage

>>> rtl/core/lagrange_interpolation.sv
// ----------------------------------------------------------------------------
// lagrange_interpolation: Lagrange polynomial over a small knot table
// Stores up to MAX_KNOTS (x, y) knots in Q16.16 and evaluates the polynomial
// at a query x in Q16.16, with a saturated Q16.16 result.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the mode (clear, append, evaluate), tdata the
//   x and y operands. Every input transfer yields exactly one output transfer:
//   tdata is the value, tuser the status (ok, duplicate knots, saturated,
//   table full).
//   Evaluation is paced by the one-bit-per-cycle divider and the shared
//   32x32 multiplier. One item is processed at a time.
//   Results sit in an output register: a new item is accepted while a result
//   waits, and the block holds its next result until the receiver takes the
//   pending one.
//   Reset empties the knot table and drops any pending result; the knot RAMs
//   themselves are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module lagrange_interpolation import lagr_pkg::*; #(
  parameter int unsigned MAX_KNOTS = MaxKnotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // [31:0] x_value, [63:32] y_value
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] value
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);

  localparam int unsigned IDX_W = $clog2(MAX_KNOTS);

  logic             in_fire;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  lagr_ctrl #(.MAX_KNOTS(MAX_KNOTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .mode_i      (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .we_o        (we),
    .waddr_o     (waddr),
    .raddr_o     (raddr)
  );

  lagr_dp #(.MAX_KNOTS(MAX_KNOTS)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_x_i    (s_axis_tdata_i[31:0]),
    .in_y_i    (s_axis_tdata_i[63:32]),
    .cmd_i     (cmd),
    .we_i      (we),
    .waddr_i   (waddr),
    .raddr_i   (raddr),
    .stat_o    (stat),
    .value_o   (m_axis_tdata_o),
    .status_o  (m_axis_tuser_o)
  );

endmodule

>>> rtl/core/lagr_ram.sv
// ----------------------------------------------------------------------------
// lagr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lagr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/lagr_div.sv
// ----------------------------------------------------------------------------
// lagr_div: radix-2 restoring divider
// Computes (num << 32) / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lagr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [63:0] quot_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] dq_q, dq_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] trial, diff;
  logic        ge;

  assign trial = {rem_q, dq_q[63]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = {num_i, 32'd0};
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      // remainder stays below den, so 32 bits hold it
      rem_d = ge ? diff[31:0] : trial[31:0];
      dq_d  = {dq_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dq_q;

endmodule

>>> rtl/core/lagr_dp.sv
// ----------------------------------------------------------------------------
// lagr_dp: interpolation datapath
// Knot RAMs, divider, shared 32x32 multiplier, Q32.32 accumulator, result reg.
// ----------------------------------------------------------------------------
module lagr_dp import lagr_pkg::*; #(
  parameter int unsigned MAX_KNOTS = MaxKnotsDef,
  localparam int unsigned IDX_W    = $clog2(MAX_KNOTS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic [31:0]        in_x_i,
  input  logic [31:0]        in_y_i,
  input  dp_cmd_t            cmd_i,
  input  logic               we_i,
  input  logic [IDX_W-1:0]   waddr_i,
  input  logic [IDX_W-1:0]   raddr_i,
  output dp_stat_t           stat_o,
  output logic [31:0]        value_o,
  output logic [1:0]         status_o
);

  logic [31:0] xq_q, yin_q, xk_q, yk_q;
  logic [31:0] xj_rd, yk_rd;

  lagr_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (xq_q),
    .raddr_i (raddr_i),
    .rdata_o (xj_rd)
  );

  lagr_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (yin_q),
    .raddr_i (raddr_i),
    .rdata_o (yk_rd)
  );

  // ratio operands; both differences are exact in 33 bits
  logic [32:0] num, den, num_abs, den_abs;
  logic        ratio_neg_q;
  logic [63:0] quot;
  logic        div_busy, div_sat;
  logic [62:0] ratio_mag;

  assign num     = {xq_q[31], xq_q} - {xj_rd[31], xj_rd};
  assign den     = {xk_q[31], xk_q} - {xj_rd[31], xj_rd};
  assign num_abs = num[32] ? (33'd0 - num) : num;
  assign den_abs = den[32] ? (33'd0 - den) : den;

  lagr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_abs[31:0]),
    .den_i   (den_abs[31:0]),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // integer part of 2^31 or more is out of Q32.32 range
  assign div_sat   = quot[63];
  assign ratio_mag = div_sat ? QLIM : quot[62:0];

  // sign-magnitude multiplier, four 32x32 partial products
  logic        basis_neg_q;
  logic [62:0] basis_mag_q;
  logic [62:0] ma_q, mb_q;
  logic        mneg_q;
  logic        mul_busy_q;
  logic [2:0]  mstep_q;
  logic [63:0] pp_q;
  logic [127:0] prod_q, pp_shift;
  logic [31:0] opa, opb;
  logic [31:0] yk_abs;
  logic [33:0] yk_neg;
  logic        mul_sat;
  logic [62:0] mul_mag;

  assign yk_neg = 34'd0 - {{2{yk_q[31]}}, yk_q};
  assign yk_abs = yk_q[31] ? yk_neg[31:0] : yk_q;

  always_comb begin
    unique case (mstep_q[1:0])
      2'd0: begin opa = ma_q[31:0];           opb = mb_q[31:0];           end
      2'd1: begin opa = {1'b0, ma_q[62:32]};  opb = mb_q[31:0];           end
      2'd2: begin opa = ma_q[31:0];           opb = {1'b0, mb_q[62:32]};  end
      default: begin opa = {1'b0, ma_q[62:32]}; opb = {1'b0, mb_q[62:32]}; end
    endcase
  end

  always_comb begin
    unique case (mstep_q)
      3'd1:       pp_shift = {64'd0, pp_q};
      3'd2, 3'd3: pp_shift = {32'd0, pp_q, 32'd0};
      3'd4:       pp_shift = {pp_q, 64'd0};
      default:    pp_shift = '0;
    endcase
  end

  assign mul_sat = |prod_q[127:95];
  assign mul_mag = mul_sat ? QLIM : prod_q[94:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      mstep_q    <= '0;
    end else if (cmd_i.mul_start) begin
      mul_busy_q <= 1'b1;
      mstep_q    <= '0;
    end else if (mul_busy_q) begin
      mstep_q <= mstep_q + 3'd1;
      if (mstep_q == 3'd4) begin
        mul_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      prod_q <= '0;
      if (cmd_i.mul_sel == MUL_RATIO) begin
        ma_q   <= basis_mag_q;
        mb_q   <= ratio_mag;
        mneg_q <= basis_neg_q ^ ratio_neg_q;
      end else begin
        ma_q   <= {15'd0, yk_abs, 16'd0};
        mb_q   <= basis_mag_q;
        mneg_q <= yk_q[31] ^ basis_neg_q;
      end
    end else if (mul_busy_q) begin
      pp_q   <= opa * opb;
      prod_q <= prod_q + pp_shift;
    end
  end

  // accumulator with symmetric saturation at +-(2^63 - 1)
  logic [63:0] acc_q, term, acc_sum;
  logic [64:0] sum;
  logic        pos_over, neg_over;
  logic        sat_q;

  assign term     = mneg_q ? (64'd0 - {1'b0, mul_mag}) : {1'b0, mul_mag};
  assign sum      = {acc_q[63], acc_q} + {term[63], term};
  assign pos_over = !sum[64] && sum[63];
  assign neg_over = sum[64] && (!sum[63] || (sum[62:0] == '0));

  always_comb begin
    if (pos_over) begin
      acc_sum = {1'b0, QLIM};
    end else if (neg_over) begin
      acc_sum = 64'h8000_0000_0000_0001;
    end else begin
      acc_sum = sum[63:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      xq_q  <= in_x_i;
      yin_q <= in_y_i;
    end
    if (cmd_i.ld_k) begin
      xk_q        <= xj_rd;
      yk_q        <= yk_rd;
      basis_neg_q <= 1'b0;
      basis_mag_q <= QONE;
    end else if (cmd_i.ld_basis) begin
      basis_neg_q <= mneg_q;
      basis_mag_q <= mul_mag;
    end
    if (cmd_i.div_start) begin
      ratio_neg_q <= num[32] ^ den[32];
    end
    if (cmd_i.eval_init) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else begin
      if (cmd_i.acc_add) begin
        acc_q <= acc_sum;
      end
      sat_q <= sat_q
             | (cmd_i.mul_start && (cmd_i.mul_sel == MUL_RATIO) && div_sat)
             | ((cmd_i.ld_basis || cmd_i.acc_add) && mul_sat)
             | (cmd_i.acc_add && (pos_over || neg_over));
    end
  end

  // Q32.32 -> Q16.16, truncate magnitude, clamp
  logic        acc_neg;
  logic [63:0] acc_abs;
  logic [47:0] m;
  logic [31:0] m_clamp, fin;
  logic        clamp_sat;

  assign acc_neg = acc_q[63];
  assign acc_abs = acc_neg ? (64'd0 - acc_q) : acc_q;
  assign m       = acc_abs[63:16];

  always_comb begin
    clamp_sat = 1'b0;
    m_clamp   = m[31:0];
    if (acc_neg && (m > 48'h8000_0000)) begin
      clamp_sat = 1'b1;
      m_clamp   = 32'h8000_0000;
    end else if (!acc_neg && (m > 48'h7FFF_FFFF)) begin
      clamp_sat = 1'b1;
      m_clamp   = 32'h7FFF_FFFF;
    end
  end

  assign fin = acc_neg ? (32'd0 - m_clamp) : m_clamp;

  logic [31:0] out_value_q;
  status_e     out_status_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      if (cmd_i.out_eval) begin
        out_value_q  <= fin;
        out_status_q <= (sat_q || clamp_sat) ? ST_SAT : ST_OK;
      end else begin
        out_value_q  <= '0;
        out_status_q <= cmd_i.out_status;
      end
    end
  end

  assign stat_o.dup      = (den == '0);
  assign stat_o.div_busy = div_busy;
  assign stat_o.mul_busy = mul_busy_q;
  assign value_o         = out_value_q;
  assign status_o        = out_status_q;

endmodule

>>> rtl/core/lagr_ctrl.sv
// ----------------------------------------------------------------------------
// lagr_ctrl: interpolation sequencer
// Walks knot pairs, issues divide/multiply/accumulate, owns the output valid.
// ----------------------------------------------------------------------------
module lagr_ctrl import lagr_pkg::*; #(
  parameter int unsigned MAX_KNOTS = MaxKnotsDef,
  localparam int unsigned IDX_W    = $clog2(MAX_KNOTS),
  localparam int unsigned CNT_W    = $clog2(MAX_KNOTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [1:0]       mode_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  input  dp_stat_t         stat_i,
  output dp_cmd_t          cmd_o,
  output logic             we_o,
  output logic [IDX_W-1:0] waddr_o,
  output logic [IDX_W-1:0] raddr_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_INIT, S_KCHK, S_KLD, S_JCHK, S_JLD,
    S_DIVW, S_MRW, S_TMUL, S_MTW, S_FINAL, S_RESULT
  } state_e;

  state_e      state_q;
  logic [CNT_W-1:0] cnt_q, k_q, j_q;
  status_e     res_status_q;
  logic        res_eval_q;
  logic        out_valid_q;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.mul_sel    = MUL_RATIO;
    cmd_o.out_status = res_status_q;
    cmd_o.out_eval   = res_eval_q;
    unique case (state_q)
      S_INIT: cmd_o.eval_init = 1'b1;
      S_KLD:  cmd_o.ld_k      = 1'b1;
      S_JLD:  cmd_o.div_start = !stat_i.dup;
      S_DIVW: cmd_o.mul_start = !stat_i.div_busy;
      S_MRW:  cmd_o.ld_basis  = !stat_i.mul_busy;
      S_TMUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_TERM;
      end
      S_MTW:    cmd_o.acc_add = !stat_i.mul_busy;
      S_RESULT: cmd_o.ld_out  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      k_q          <= '0;
      j_q          <= '0;
      res_status_q <= ST_OK;
      res_eval_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // in S_RESULT the valid is driven by the result load below
      if (out_valid_q && out_ready_i && (state_q != S_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire_i) begin
            res_status_q <= ST_OK;
            res_eval_q   <= 1'b0;
            unique case (mode_e'(mode_i))
              MODE_CLEAR: begin
                cnt_q   <= '0;
                state_q <= S_RESULT;
              end
              MODE_APPEND: begin
                if (cnt_q == CNT_W'(MAX_KNOTS)) begin
                  res_status_q <= ST_FULL;
                  state_q      <= S_RESULT;
                end else begin
                  state_q <= S_WRITE;
                end
              end
              MODE_EVAL: state_q <= S_INIT;
              MODE_NONE: state_q <= S_RESULT;
            endcase
          end
        end
        S_WRITE: begin
          cnt_q   <= cnt_q + CNT_W'(1);
          state_q <= S_RESULT;
        end
        S_INIT: begin
          k_q     <= '0;
          state_q <= S_KCHK;
        end
        S_KCHK: state_q <= (k_q == cnt_q) ? S_FINAL : S_KLD;
        S_KLD: begin
          j_q     <= '0;
          state_q <= S_JCHK;
        end
        S_JCHK: begin
          if (j_q == cnt_q) begin
            state_q <= S_TMUL;
          end else if (j_q == k_q) begin
            j_q <= j_q + CNT_W'(1);
          end else begin
            state_q <= S_JLD;
          end
        end
        S_JLD: begin
          if (stat_i.dup) begin
            res_status_q <= ST_DUP;
            state_q      <= S_RESULT;
          end else begin
            state_q <= S_DIVW;
          end
        end
        S_DIVW: if (!stat_i.div_busy) state_q <= S_MRW;
        S_MRW: begin
          if (!stat_i.mul_busy) begin
            j_q     <= j_q + CNT_W'(1);
            state_q <= S_JCHK;
          end
        end
        S_TMUL: state_q <= S_MTW;
        S_MTW: begin
          if (!stat_i.mul_busy) begin
            k_q     <= k_q + CNT_W'(1);
            state_q <= S_KCHK;
          end
        end
        S_FINAL: begin
          res_eval_q <= 1'b1;
          state_q    <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign we_o        = (state_q == S_WRITE);
  assign waddr_o     = cnt_q[IDX_W-1:0];
  assign raddr_o     = (state_q == S_JCHK) ? j_q[IDX_W-1:0] : k_q[IDX_W-1:0];

endmodule
